FILE: rtl/psl_pkg.sv
// Shared types, offsets and codes for the partition start locator.
package psl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] byte_offset;
        logic       read_failed;
    } psl_in_t;

    typedef struct packed {
        logic [31:0] sector_number;
        logic        is_final;
    } psl_out_t;

    // Walk state carried from one byte to the next
    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  part_type;
        logic [31:0] captured_lba;
        logic        signature_ok;
    } psl_state_t;

    localparam logic [1:0] PH_MBR     = 2'd0;
    localparam logic [1:0] PH_GPT_HDR = 2'd1;
    localparam logic [1:0] PH_ENTRY   = 2'd2;

    localparam logic [8:0] MBR_TYPE_OFF  = 9'd450;
    localparam logic [8:0] MBR_LBA_OFF   = 9'd454;
    localparam logic [8:0] MBR_SIG_OFF   = 9'd510;
    localparam logic [8:0] GPT_LBA_OFF   = 9'd72;
    localparam logic [8:0] ENTRY_LBA_OFF = 9'd32;
    localparam logic [8:0] LAST_OFF      = 9'd511;
    localparam logic [8:0] MAGIC_LEN     = 9'd8;

    localparam logic [7:0] SIG_LO      = 8'h55;
    localparam logic [7:0] SIG_HI      = 8'hAA;
    localparam logic [7:0] TYPE_GPT    = 8'hEE;
    localparam logic [7:0] TYPE_FAT32  = 8'h0B;
    localparam logic [7:0] TYPE_FAT32L = 8'h0C;
    localparam logic [7:0] TYPE_NTFS   = 8'h07;

    localparam logic [31:0] GPT_HDR_SECTOR = 32'd1;

    localparam psl_state_t STATE_RESET = '{
        phase:        PH_MBR,
        part_type:    8'h00,
        captured_lba: 32'h0000_0000,
        signature_ok: 1'b1
    };

    // GPT header signature "EFI PART"
    function automatic logic [7:0] efi_magic(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h45;
            3'd1: ch = 8'h46;
            3'd2: ch = 8'h49;
            3'd3: ch = 8'h20;
            3'd4: ch = 8'h50;
            3'd5: ch = 8'h41;
            3'd6: ch = 8'h52;
            default: ch = 8'h54;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/psl_step.sv
// Per-byte next-state and result logic of the partition start locator.
module psl_step (
    input  psl_pkg::psl_state_t cur,
    input  psl_pkg::psl_in_t    item,
    output psl_pkg::psl_state_t nxt,
    output logic                res_valid,
    output psl_pkg::psl_out_t   res
);
    import psl_pkg::*;

    logic [8:0]  grab_base;
    logic [8:0]  grab_diff;
    logic        grab_hit;
    logic [31:0] lba_grabbed;
    logic        sig_ok;
    logic        is_last;
    logic        known_type;

    always_comb begin
        case (cur.phase)
            PH_GPT_HDR: grab_base = GPT_LBA_OFF;
            PH_ENTRY:   grab_base = ENTRY_LBA_OFF;
            default:    grab_base = MBR_LBA_OFF;
        endcase
    end

    // Place one little-endian byte into the word being gathered
    assign grab_diff = item.byte_offset - grab_base;
    assign grab_hit  = (grab_diff < 9'd4);
    always_comb begin
        lba_grabbed = cur.captured_lba;
        if (grab_hit) begin
            case (grab_diff[1:0])
                2'd0:    lba_grabbed[7:0]   = item.data_byte;
                2'd1:    lba_grabbed[15:8]  = item.data_byte;
                2'd2:    lba_grabbed[23:16] = item.data_byte;
                default: lba_grabbed[31:24] = item.data_byte;
            endcase
        end
    end

    assign is_last = (item.byte_offset == LAST_OFF);

    always_comb begin
        nxt        = cur;
        res_valid  = 1'b0;
        res        = '0;
        sig_ok     = cur.signature_ok;
        known_type = 1'b0;

        if (item.read_failed) begin
            res_valid = 1'b1;
            res       = '{sector_number: 32'd0, is_final: 1'b1};
            nxt       = STATE_RESET;
        end else begin
            nxt.captured_lba = lba_grabbed;
            case (cur.phase)
                PH_GPT_HDR: begin
                    if (item.byte_offset < MAGIC_LEN &&
                        item.data_byte != efi_magic(item.byte_offset[2:0])) begin
                        sig_ok = 1'b0;
                    end
                    nxt.signature_ok = sig_ok;
                    if (is_last) begin
                        res_valid = 1'b1;
                        if (!sig_ok) begin
                            res = '{sector_number: 32'd0, is_final: 1'b1};
                            nxt = STATE_RESET;
                        end else begin
                            res = '{sector_number: lba_grabbed, is_final: 1'b0};
                            nxt.phase        = PH_ENTRY;
                            nxt.captured_lba = '0;
                            nxt.signature_ok = 1'b1;
                        end
                    end
                end
                PH_ENTRY: begin
                    if (is_last) begin
                        res_valid = 1'b1;
                        res = '{sector_number: lba_grabbed, is_final: 1'b1};
                        nxt = STATE_RESET;
                    end
                end
                default: begin
                    if (item.byte_offset == MBR_TYPE_OFF) begin
                        nxt.part_type = item.data_byte;
                    end
                    if (item.byte_offset == MBR_SIG_OFF && item.data_byte != SIG_LO) begin
                        sig_ok = 1'b0;
                    end
                    if (is_last && item.data_byte != SIG_HI) begin
                        sig_ok = 1'b0;
                    end
                    nxt.signature_ok = sig_ok;
                    known_type = (cur.part_type == TYPE_FAT32) ||
                                 (cur.part_type == TYPE_FAT32L) ||
                                 (cur.part_type == TYPE_NTFS);
                    if (is_last) begin
                        res_valid = 1'b1;
                        if (sig_ok && cur.part_type == TYPE_GPT) begin
                            res = '{sector_number: GPT_HDR_SECTOR, is_final: 1'b0};
                            nxt.phase        = PH_GPT_HDR;
                            nxt.captured_lba = '0;
                            nxt.signature_ok = 1'b1;
                        end else begin
                            res.is_final      = 1'b1;
                            res.sector_number = (sig_ok && known_type) ? lba_grabbed : 32'd0;
                            nxt = STATE_RESET;
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/partition_start_locator.sv
// Top level of the partition start locator: input register, walk state, result register.
//
//  channel | ports                     | payload            | direction
//  --------+---------------------------+--------------------+----------
//  s_      | s_valid, s_ready, s_data  | psl_in_t  (18 b)   | in
//  m_      | m_valid, m_ready, m_data  | psl_out_t (33 b)   | out
//
// One sector byte per transfer, one byte per cycle sustained while no result is held
// back. A byte waits in the input register, where the walk-state update and result
// decision (a compare and a byte insert) run on it and land in the result register,
// so the result of the byte at offset 511 or a failed read passes both registers.
// Reset (aresetn low, synchronous) empties both registers and returns the walk to
// sector 0. A stalled result only holds back a byte that would itself produce a
// result; other bytes keep flowing.
module partition_start_locator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  psl_pkg::psl_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output psl_pkg::psl_out_t  m_data
);
    import psl_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    psl_in_t    in_data_reg;

    psl_state_t state_reg;
    psl_state_t state_next;
    psl_state_t step_state;

    logic       out_valid_reg;
    logic       out_valid_next;
    psl_out_t   out_data_reg;

    logic       step_res_valid;
    psl_out_t   step_res;
    logic       step_fire;

    psl_step u_step (
        .cur       (state_reg),
        .item      (in_data_reg),
        .nxt       (step_state),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    // Advance the held byte unless it has a result and the result slot is blocked
    assign step_fire = in_valid_reg && (!step_res_valid || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    assign state_next = step_fire ? step_state : state_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_fire && step_res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_fire && step_res_valid) begin
            out_data_reg <= step_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A result comes only from the last byte of a sector or a failed read
    a_result_at_sector_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && step_res_valid |->
            (in_data_reg.read_failed || in_data_reg.byte_offset == LAST_OFF))
        else $error("result produced mid-sector");

    // Any final answer restarts the walk at sector 0
    a_final_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && step_res_valid && step_res.is_final |=>
            (state_reg.phase == PH_MBR && state_reg.part_type == 8'h00 &&
             state_reg.captured_lba == 32'd0 && state_reg.signature_ok))
        else $error("walk state not cleared after final answer");

    // A read request moves the walk off sector 0
    a_request_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && step_res_valid && !step_res.is_final |=>
            (state_reg.phase != PH_MBR && state_reg.captured_lba == 32'd0))
        else $error("read request left walk on sector 0");

    // From sector 0 the only request is for the GPT header
    a_mbr_requests_header: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && step_res_valid && !step_res.is_final && state_reg.phase == PH_MBR |->
            step_res.sector_number == GPT_HDR_SECTOR)
        else $error("unexpected sector requested from sector 0");

endmodule

FILE: bench/partition_start_locator_tb.sv
// Self-checking testbench for the partition start locator.
`timescale 1ns / 1ps

module partition_start_locator_tb;
    import psl_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SQUEEZE_LEN  = 300;   // cycles the result side holds off
    localparam int DRAIN_CYCLES = 10;    // result passes the input and result registers after its byte
    localparam logic [63:0] EFI_TEXT = "EFI PART";

    // Expected answers of the partition walk. The walk state is kept here and
    // stepped once per accepted transfer, in acceptance order.
    class sector_answer_book;
        logic [1:0]  phase;
        logic [7:0]  part_type;
        logic [31:0] lba_acc;
        bit          sig_ok;
        psl_out_t    answers_due[$];
        int unsigned faults;

        function new();
            restart();
        endfunction

        function void restart();
            phase     = PH_MBR;
            part_type = 8'h00;
            lba_acc   = 32'h0;
            sig_ok    = 1'b1;
        endfunction

        // Insert a little-endian byte if the offset falls in the 4-byte window
        function void insert_lba_byte(int off, int base, logic [7:0] b);
            if (off >= base && off < base + 4)
                lba_acc[(off - base) * 8 +: 8] = b;
        endfunction

        // Queue an answer or a read request; a final answer restarts the walk
        function void issue(logic [31:0] sector, bit fin);
            psl_out_t ans;
            ans.sector_number = sector;
            ans.is_final      = fin;
            answers_due.push_back(ans);
            if (fin) begin
                restart();
            end else begin
                lba_acc = 32'h0;
                sig_ok  = 1'b1;
            end
        endfunction

        function void note_byte(psl_in_t item);
            logic [7:0] b;
            int         off;
            b   = item.data_byte;
            off = item.byte_offset;
            if (item.read_failed) begin
                issue(32'h0, 1'b1);
                return;
            end
            case (phase)
                PH_GPT_HDR: begin
                    if (off < 8 && b != EFI_TEXT[63 - 8 * off -: 8])
                        sig_ok = 1'b0;
                    insert_lba_byte(off, GPT_LBA_OFF, b);
                    if (off == LAST_OFF) begin
                        if (!sig_ok) begin
                            issue(32'h0, 1'b1);
                        end else begin
                            issue(lba_acc, 1'b0);
                            phase = PH_ENTRY;
                        end
                    end
                end
                PH_ENTRY: begin
                    insert_lba_byte(off, ENTRY_LBA_OFF, b);
                    if (off == LAST_OFF)
                        issue(lba_acc, 1'b1);
                end
                default: begin
                    // master boot sector; the unused phase value lands here too
                    if (off == MBR_TYPE_OFF)
                        part_type = b;
                    insert_lba_byte(off, MBR_LBA_OFF, b);
                    if (off == MBR_SIG_OFF && b != SIG_LO)
                        sig_ok = 1'b0;
                    if (off == LAST_OFF) begin
                        if (b != SIG_HI)
                            sig_ok = 1'b0;
                        if (!sig_ok) begin
                            issue(32'h0, 1'b1);
                        end else if (part_type == TYPE_GPT) begin
                            issue(GPT_HDR_SECTOR, 1'b0);
                            phase = PH_GPT_HDR;
                        end else if (part_type == TYPE_FAT32 || part_type == TYPE_FAT32L ||
                                     part_type == TYPE_NTFS) begin
                            issue(lba_acc, 1'b1);
                        end else begin
                            issue(32'h0, 1'b1);
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            faults++;
        endtask

        task check_answer(psl_out_t got);
            psl_out_t want;
            if (answers_due.size() == 0) begin
                report($sformatf("unexpected result: sector %0d final %0b",
                                 got.sector_number, got.is_final));
                return;
            end
            want = answers_due.pop_front();
            if (got.sector_number !== want.sector_number)
                report($sformatf("sector_number %0d, expected %0d",
                                 got.sector_number, want.sector_number));
            if (got.is_final !== want.is_final)
                report($sformatf("is_final %0b, expected %0b (sector %0d)",
                                 got.is_final, want.is_final, want.sector_number));
        endtask
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    psl_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    psl_out_t m_data;

    sector_answer_book book = new();

    int  items_sent  = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;   // both sides stop idling while set
    int  hold_reqs   = 0;      // raised by the stimulus, served by the result side
    int  hold_served = 0;
    int  hold_left   = 0;

    partition_start_locator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Bound the run: a stuck handshake or a missing result ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: check each transfer against the oldest expectation, then pick
    // next cycle's ready. A pending hold request turns into a long hold-off,
    // counted down here, so the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_answer(m_data);
        if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = SQUEEZE_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // Offer one transfer, idling a random few cycles first, and hold it until taken.
    // Valid is driven once per step, so back-to-back items keep it high.
    task automatic push_item(input psl_in_t item);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 18)
                gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        book.note_byte(item);
        items_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b, input int off);
        psl_in_t item;
        item.data_byte   = b;
        item.byte_offset = off[8:0];
        item.read_failed = 1'b0;
        push_item(item);
    endtask

    // Failed read: byte and offset carry junk that the block must ignore
    task automatic push_fail();
        psl_in_t item;
        item.data_byte   = 8'($urandom);
        item.byte_offset = 9'($urandom);
        item.read_failed = 1'b1;
        push_item(item);
    endtask

    // Filler bytes at random offsets inside [lo, hi]
    task automatic scatter(input int lo, input int hi, input int n);
        repeat (n) push_byte(8'($urandom), $urandom_range(lo, hi));
    endtask

    // Four little-endian bytes; with gaps set, an occasional byte goes missing
    task automatic send_lba(input int base, input logic [31:0] value, input bit gaps);
        for (int i = 0; i < 4; i++)
            if (!gaps || $urandom_range(0, 19) != 0)
                push_byte(value[8 * i +: 8], base + i);
    endtask

    function automatic logic [31:0] pick_lba();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 4096);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_mbr();
        logic [7:0] ptype;
        case ($urandom_range(0, 9))
            0, 1:    ptype = TYPE_FAT32;
            2:       ptype = TYPE_FAT32L;
            3:       ptype = TYPE_NTFS;
            4, 5, 6: ptype = TYPE_GPT;
            default: ptype = 8'($urandom);
        endcase
        scatter(0, MBR_TYPE_OFF - 5, $urandom_range(0, 3));
        if ($urandom_range(0, 19) != 0)
            push_byte(ptype, MBR_TYPE_OFF);
        send_lba(MBR_LBA_OFF, pick_lba(), 1'b1);
        scatter(MBR_LBA_OFF + 4, MBR_SIG_OFF - 1, $urandom_range(0, 2));
        push_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : SIG_LO, MBR_SIG_OFF);
        push_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : SIG_HI, LAST_OFF);
    endtask

    task automatic send_gpt_header();
        logic [7:0] ch;
        for (int i = 0; i < MAGIC_LEN; i++) begin
            ch = EFI_TEXT[63 - 8 * i -: 8];
            if ($urandom_range(0, 39) == 0)
                ch = 8'($urandom);
            if ($urandom_range(0, 19) != 0)
                push_byte(ch, i);
        end
        scatter(MAGIC_LEN, GPT_LBA_OFF - 1, $urandom_range(0, 2));
        send_lba(GPT_LBA_OFF, pick_lba(), 1'b1);
        scatter(GPT_LBA_OFF + 4, LAST_OFF - 1, $urandom_range(0, 3));
        push_byte(8'($urandom), LAST_OFF);
    endtask

    task automatic send_entry();
        scatter(0, ENTRY_LBA_OFF - 1, $urandom_range(0, 2));
        send_lba(ENTRY_LBA_OFF, pick_lba(), 1'b1);
        scatter(ENTRY_LBA_OFF + 4, LAST_OFF - 1, $urandom_range(0, 3));
        push_byte(8'($urandom), LAST_OFF);
    endtask

    // Ask for a long hold-off and keep offering bytes that each produce a
    // result, so both internal registers fill and the input side stalls.
    task automatic squeeze();
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 16; i++)
            if (i % 2 == 0)
                push_fail();
            else
                push_byte(8'($urandom), LAST_OFF);
    endtask

    initial begin
        int next_squeeze;
        int pick;
        next_squeeze = 300;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: failed read right out of reset
        push_fail();
        // FAT32 (LBA) type with an all-ones start
        push_byte(TYPE_FAT32L, MBR_TYPE_OFF);
        send_lba(MBR_LBA_OFF, 32'hFFFF_FFFF, 1'b0);
        push_byte(SIG_LO, MBR_SIG_OFF);
        push_byte(SIG_HI, LAST_OFF);
        // NTFS type, start bytes never delivered so the answer is zero
        push_byte(TYPE_NTFS, MBR_TYPE_OFF);
        push_byte(SIG_LO, MBR_SIG_OFF);
        push_byte(SIG_HI, LAST_OFF);
        // Lone last byte with a bad signature: superfloppy
        push_byte(8'h00, LAST_OFF);
        // Protective MBR, header without magic bytes (nothing to mismatch), then entry
        push_byte(TYPE_GPT, MBR_TYPE_OFF);
        push_byte(SIG_LO, MBR_SIG_OFF);
        push_byte(SIG_HI, LAST_OFF);
        send_lba(GPT_LBA_OFF, 32'h0000_0002, 1'b0);
        push_byte(8'hFF, LAST_OFF);
        send_lba(ENTRY_LBA_OFF, 32'h8000_0800, 1'b0);
        push_byte(8'h00, LAST_OFF);

        // Random: mostly well-formed sectors for whatever the walk expects next,
        // with failed reads and stray bytes mixed in.
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 500 && items_sent < 750);
            if (items_sent >= next_squeeze) begin
                squeeze();
                next_squeeze += 500;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_fail();
            end else if (pick < 14) begin
                scatter(0, LAST_OFF, $urandom_range(1, 6));
            end else begin
                case (book.phase)
                    PH_GPT_HDR: send_gpt_header();
                    PH_ENTRY:   send_entry();
                    default:    send_mbr();
                endcase
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Drain, then allow a few cycles for any stray result to show
        while (book.answers_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (book.faults == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
